[src/ctwt_pkg.sv]
package ctwt_pkg;

    localparam int TIMER_BITS_DEF    = 16;
    localparam int MAX_CYLINDERS_DEF = 16;

    localparam int CYL_W = 5;
    localparam int CNT_W = 16;
    localparam int DEG_W = 8;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CYL_W-1:0] CYL_COUNT_RESET = CYL_W'(8);

    localparam int WHEEL0_DIVISOR = 45;

    localparam logic WHEEL_SINGLE = 1'b0;
    localparam logic WHEEL_QUAD   = 1'b1;

    typedef enum logic [1:0] {
        REQ_CRANK   = 2'd0,
        REQ_CAM     = 2'd1,
        REQ_COMPARE = 2'd2
    } t_req_type;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WHEEL_MODE    = 3'd0,
        CFG_CYL_COUNT     = 3'd1,
        CFG_MECH_ADVANCE  = 3'd2,
        CFG_WINDOW_OPEN   = 3'd3,
        CFG_WINDOW_LENGTH = 3'd4
    } t_cfg_index;

    typedef enum logic [1:0] {
        PHASE_FIRST  = 2'd0,
        PHASE_SECOND = 2'd1,
        PHASE_PREV   = 2'd2,
        PHASE_LAST   = 2'd3
    } t_edge_phase;

endpackage

[src/crank_trigger_window_timer.sv]
// A result is registered in the output register, or in a skid entry while that one waits.
// Throughput: one request per cycle; a two-entry output buffer keeps input accepted while
// one result waits, so input stalls only when both entries are full.
// Each request is decoded, divided, multiplied and added in one pass between the state
// registers and the output register, which limits the clock rate.
// Reset is synchronous and active low; it resets all but the output and skid data.
module crank_trigger_window_timer #(
    parameter int TIMER_BITS    = ctwt_pkg::TIMER_BITS_DEF,
    parameter int MAX_CYLINDERS = ctwt_pkg::MAX_CYLINDERS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ctwt_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ctwt_pkg::DEG_W-1:0]       i_cfg_data,

    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_req_type,
    input  logic [TIMER_BITS-1:0]            i_stamp,
    input  logic [TIMER_BITS-1:0]            i_counter_now,
    input  logic                             i_crank_level,
    input  logic                             i_cam_level,

    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [TIMER_BITS-1:0]            o_compare_value,
    output logic                             o_compare_enabled,
    output logic                             o_window_active,
    output logic                             o_window_closed,
    output logic [ctwt_pkg::CYL_W-1:0]       o_closed_cylinder,
    output logic [TIMER_BITS-1:0]            o_ticks_per_quad_deg,
    output logic [ctwt_pkg::CNT_W-1:0]       o_sync_loss_count,
    output logic [ctwt_pkg::CNT_W-1:0]       o_overrun_count
);

    localparam int W     = TIMER_BITS;
    localparam int CYL_W = ctwt_pkg::CYL_W;
    localparam int CNT_W = ctwt_pkg::CNT_W;
    localparam int DEG_W = ctwt_pkg::DEG_W;

    localparam logic [CYL_W-1:0] MAX_CYL = CYL_W'(MAX_CYLINDERS);
    localparam logic [CYL_W-1:0] CYL_INDEX_RESET =
        (ctwt_pkg::CYL_COUNT_RESET > MAX_CYL) ? MAX_CYL : ctwt_pkg::CYL_COUNT_RESET;

    localparam logic [W-1:0] DIV45 = W'(ctwt_pkg::WHEEL0_DIVISOR);
    localparam logic [W:0] RECIP45 =
        (W+1)'((64'd1 << (W + 6)) / 64'(ctwt_pkg::WHEEL0_DIVISOR));

    typedef struct packed {
        logic [W-1:0]     compare_value;
        logic             compare_enabled;
        logic             window_active;
        logic             window_closed;
        logic [CYL_W-1:0] closed_cylinder;
        logic [W-1:0]     ticks;
        logic [CNT_W-1:0] sync_losses;
        logic [CNT_W-1:0] overruns;
    } t_result;

    logic             r_wheel_mode;
    logic [CYL_W-1:0] r_cyl_count;
    logic [DEG_W-1:0] r_mech_advance;
    logic [DEG_W-1:0] r_window_open;
    logic [DEG_W-1:0] r_window_length;

    logic [W-1:0]     r_last_stamp,     n_last_stamp;
    logic [W-1:0]     r_prev_stamp,     n_prev_stamp;
    logic [W-1:0]     r_ticks,          n_ticks;
    logic [CYL_W-1:0] r_cyl_index,      n_cyl_index;
    logic [1:0]       r_edge_phase,     n_edge_phase;
    logic             r_cam_synced,     n_cam_synced;
    logic             r_window_open_f,  n_window_open_f;
    logic [W-1:0]     r_compare,        n_compare;
    logic             r_compare_armed,  n_compare_armed;
    logic [CNT_W-1:0] r_sync_losses,    n_sync_losses;
    logic [CNT_W-1:0] r_overruns,       n_overruns;
    logic             n_closed;

    t_result          r_out,  n_result;
    t_result          r_skid;
    logic             r_out_valid;
    logic             r_skid_valid;

    logic             accept;
    logic             out_fire;
    logic [CYL_W-1:0] eff_count;
    logic             noise;
    logic [W-1:0]     diff;
    logic [2*W:0]     d45_prod;
    logic [W-1:0]     q45_est;
    logic [W-1:0]     q45_rem;
    logic [W-1:0]     q45;
    logic [W+1:0]     d5_a;
    logic [W+1:0]     d5_b;
    logic [W+1:0]     d5_c;
    logic [W-1:0]     q5;
    logic [W-1:0]     arm_ticks;
    logic [DEG_W:0]   arm_deg;
    logic [W+DEG_W:0] arm_prod;
    logic [W+DEG_W-1:0] len_prod;
    logic [W-1:0]     arm_value;
    logic [W-1:0]     close_value;
    logic             arm;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_valid;
    assign accept      = i_in_valid && o_in_ready;
    assign out_fire    = r_out_valid && i_out_ready;

    assign eff_count = (r_cyl_count > MAX_CYL) ? MAX_CYL : r_cyl_count;
    assign noise     = (i_stamp == r_last_stamp) || (W'(r_last_stamp + W'(1)) == i_stamp);
    assign diff      = W'(i_stamp - r_prev_stamp);

    // Division by 45 through a reciprocal; the estimate is exact or one low.
    assign d45_prod = (2*W+1)'(diff) * (2*W+1)'(RECIP45);
    assign q45_est  = W'(d45_prod >> (W + 6));
    assign q45_rem  = W'(diff - W'(q45_est * DIV45));
    assign q45      = (q45_rem >= DIV45) ? W'(q45_est + W'(1)) : q45_est;

    // Shift-add approximation of division by 5.
    assign d5_a = ((W+2)'(diff >> 1) + (W+2)'(diff)) >> 1;
    assign d5_b = (d5_a >> 4) + d5_a;
    assign d5_c = ((d5_b >> 8) + d5_b) >> 2;
    assign q5   = W'(d5_c);

    assign arm_ticks   = (r_wheel_mode == ctwt_pkg::WHEEL_QUAD) ? q5 : q45;
    assign arm_deg     = (DEG_W+1)'(r_mech_advance) + (DEG_W+1)'(r_window_open);
    assign arm_prod    = (W+DEG_W+1)'(arm_deg) * (W+DEG_W+1)'(arm_ticks);
    assign arm_value   = W'(i_stamp + W'(arm_prod >> 2));
    assign len_prod    = (W+DEG_W)'(r_window_length) * (W+DEG_W)'(r_ticks);
    assign close_value = W'(r_compare + W'(len_prod >> 2));

    always_comb begin
        n_last_stamp    = r_last_stamp;
        n_prev_stamp    = r_prev_stamp;
        n_ticks         = r_ticks;
        n_cyl_index     = r_cyl_index;
        n_edge_phase    = r_edge_phase;
        n_cam_synced    = r_cam_synced;
        n_window_open_f = r_window_open_f;
        n_compare       = r_compare;
        n_compare_armed = r_compare_armed;
        n_sync_losses   = r_sync_losses;
        n_overruns      = r_overruns;
        n_closed        = 1'b0;
        arm             = 1'b0;

        case (ctwt_pkg::t_req_type'(i_req_type))
            ctwt_pkg::REQ_CRANK: begin
                if (!noise) begin
                    if (r_wheel_mode == ctwt_pkg::WHEEL_SINGLE) begin
                        if (i_cam_level && !i_crank_level) begin
                            if (r_cyl_index == eff_count || r_cyl_index == '0) begin
                                n_cyl_index = '0;
                            end else begin
                                n_sync_losses = r_sync_losses + CNT_W'(1);
                                n_cyl_index   = eff_count;
                            end
                        end else begin
                            n_last_stamp = i_stamp;
                            if (r_cyl_index < eff_count) begin
                                n_ticks      = q45;
                                n_prev_stamp = i_stamp;
                                arm          = 1'b1;
                            end
                        end
                    end else if (r_cam_synced) begin
                        n_edge_phase = r_edge_phase + 2'd1;
                        if (r_edge_phase == ctwt_pkg::PHASE_PREV) begin
                            n_prev_stamp = i_stamp;
                        end else if (r_edge_phase == ctwt_pkg::PHASE_LAST) begin
                            n_last_stamp = i_stamp;
                            n_ticks      = q5;
                            n_edge_phase = ctwt_pkg::PHASE_FIRST;
                            arm          = 1'b1;
                        end
                    end
                end
            end
            ctwt_pkg::REQ_CAM: begin
                if (r_wheel_mode == ctwt_pkg::WHEEL_QUAD && i_crank_level) begin
                    n_cyl_index = '0;
                    if (r_edge_phase != ctwt_pkg::PHASE_FIRST) begin
                        n_sync_losses = r_sync_losses + CNT_W'(1);
                    end
                    n_edge_phase = ctwt_pkg::PHASE_FIRST;
                    n_cam_synced = 1'b1;
                end
            end
            ctwt_pkg::REQ_COMPARE: begin
                if (r_compare_armed) begin
                    if (r_window_open_f) begin
                        n_compare       = close_value;
                        n_window_open_f = 1'b0;
                        if (i_counter_now > close_value) begin
                            n_overruns = r_overruns + CNT_W'(1);
                        end
                    end else begin
                        n_compare_armed = 1'b0;
                        n_closed        = 1'b1;
                        if (r_cyl_index < eff_count) begin
                            if (CYL_W'(r_cyl_index + CYL_W'(1)) == eff_count) begin
                                n_cyl_index = '0;
                            end else begin
                                n_cyl_index = r_cyl_index + CYL_W'(1);
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        if (arm) begin
            n_compare       = arm_value;
            n_compare_armed = 1'b1;
            n_window_open_f = 1'b1;
        end

        n_result.compare_value   = n_compare;
        n_result.compare_enabled = n_compare_armed;
        n_result.window_active   = n_window_open_f;
        n_result.window_closed   = n_closed;
        n_result.closed_cylinder = r_cyl_index;
        n_result.ticks           = n_ticks;
        n_result.sync_losses     = n_sync_losses;
        n_result.overruns        = n_overruns;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_mode    <= ctwt_pkg::WHEEL_SINGLE;
            r_cyl_count     <= ctwt_pkg::CYL_COUNT_RESET;
            r_mech_advance  <= '0;
            r_window_open   <= '0;
            r_window_length <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (ctwt_pkg::t_cfg_index'(i_cfg_index))
                ctwt_pkg::CFG_WHEEL_MODE:    r_wheel_mode    <= i_cfg_data[0];
                ctwt_pkg::CFG_CYL_COUNT:     r_cyl_count     <= i_cfg_data[CYL_W-1:0];
                ctwt_pkg::CFG_MECH_ADVANCE:  r_mech_advance  <= i_cfg_data;
                ctwt_pkg::CFG_WINDOW_OPEN:   r_window_open   <= i_cfg_data;
                ctwt_pkg::CFG_WINDOW_LENGTH: r_window_length <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_stamp    <= '0;
            r_prev_stamp    <= '0;
            r_ticks         <= '0;
            r_cyl_index     <= CYL_INDEX_RESET;
            r_edge_phase    <= ctwt_pkg::PHASE_FIRST;
            r_cam_synced    <= 1'b0;
            r_window_open_f <= 1'b0;
            r_compare       <= '0;
            r_compare_armed <= 1'b0;
            r_sync_losses   <= '0;
            r_overruns      <= '0;
        end else if (accept) begin
            r_last_stamp    <= n_last_stamp;
            r_prev_stamp    <= n_prev_stamp;
            r_ticks         <= n_ticks;
            r_cyl_index     <= n_cyl_index;
            r_edge_phase    <= n_edge_phase;
            r_cam_synced    <= n_cam_synced;
            r_window_open_f <= n_window_open_f;
            r_compare       <= n_compare;
            r_compare_armed <= n_compare_armed;
            r_sync_losses   <= n_sync_losses;
            r_overruns      <= n_overruns;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (!r_out_valid || out_fire) begin
                r_out <= n_result;
            end else begin
                r_skid <= n_result;
            end
        end else if (out_fire && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_compare_value      = r_out.compare_value;
    assign o_compare_enabled    = r_out.compare_enabled;
    assign o_window_active      = r_out.window_active;
    assign o_window_closed      = r_out.window_closed;
    assign o_closed_cylinder    = r_out.closed_cylinder;
    assign o_ticks_per_quad_deg = r_out.ticks;
    assign o_sync_loss_count    = r_out.sync_losses;
    assign o_overrun_count      = r_out.overruns;

endmodule
